// ----- src/puv_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// puv_pkg: shared types and constants of the printable UTF-8 validator
// State record, lead byte limits and the per-code-point legality check.
// ----------------------------------------------------------------------------
package puv_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CODE_W = 21;

    // Lead byte ranges
    localparam logic [BYTE_W-1:0] LEAD2_LO  = 8'hC2;
    localparam logic [BYTE_W-1:0] LEAD2_HI  = 8'hDF;
    localparam logic [BYTE_W-1:0] LEAD3_LO  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD3_HI  = 8'hEF;
    localparam logic [BYTE_W-1:0] LEAD4_LO  = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD4_HI  = 8'hF4;
    localparam logic [BYTE_W-1:0] CONT_MASK = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_TAG  = 8'h80;
    localparam logic [BYTE_W-1:0] ASCII_TOP = 8'h80;

    // Code point limits
    localparam logic [CODE_W-1:0] MIN_CLS1   = 21'h000080;
    localparam logic [CODE_W-1:0] MIN_CLS2   = 21'h000800;
    localparam logic [CODE_W-1:0] MIN_CLS3   = 21'h010000;
    localparam logic [CODE_W-1:0] CTRL_LIMIT = 21'h000020;
    localparam logic [CODE_W-1:0] DEL_LO     = 21'h00007F;
    localparam logic [CODE_W-1:0] C1_HI      = 21'h00009F;
    localparam logic [CODE_W-1:0] SURR_LO    = 21'h00D800;
    localparam logic [CODE_W-1:0] SURR_HI    = 21'h00DFFF;
    localparam logic [CODE_W-1:0] CODE_MAX   = 21'h10FFFF;

    // Sequence length class
    typedef enum logic [1:0] {
        CLS_ONE   = 2'd0,
        CLS_TWO   = 2'd1,
        CLS_THREE = 2'd2,
        CLS_FOUR  = 2'd3
    } len_cls_t;

    typedef struct packed {
        logic [1:0]        bytes_owed;
        logic [CODE_W-1:0] partial_code;
        len_cls_t          length_class;
        logic              error_seen;
    } puv_state_t;

    localparam puv_state_t STATE_IDLE = '{
        bytes_owed:   2'd0,
        partial_code: '0,
        length_class: CLS_ONE,
        error_seen:   1'b0
    };

    localparam puv_state_t STATE_ERROR = '{
        bytes_owed:   2'd0,
        partial_code: '0,
        length_class: CLS_ONE,
        error_seen:   1'b1
    };

    // True when a finished code point breaks a rule.
    function automatic logic code_is_bad(input logic [CODE_W-1:0] code,
                                         input len_cls_t cls);
        logic [CODE_W-1:0] minimum;
        case (cls)
            CLS_TWO:   minimum = MIN_CLS1;
            CLS_THREE: minimum = MIN_CLS2;
            CLS_FOUR:  minimum = MIN_CLS3;
            default:   minimum = '0;
        endcase
        return (code < minimum) || (code < CTRL_LIMIT)
            || ((code >= DEL_LO) && (code <= C1_HI))
            || ((code >= SURR_LO) && (code <= SURR_HI))
            || (code > CODE_MAX);
    endfunction

endpackage
`default_nettype wire

// ----- src/puv_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// puv_in_if: byte channel into the validator
// One item is one string byte plus its end marker.
// ----------------------------------------------------------------------------
interface puv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

// ----- src/puv_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// puv_out_if: result channel out of the validator
// One item per input byte: running verdict and end-of-string flag.
// ----------------------------------------------------------------------------
interface puv_out_if;
    logic valid;
    logic ready;
    logic valid_so_far;
    logic end_of_string;

    modport source (output valid, output valid_so_far, output end_of_string, input ready);
    modport sink   (input valid, input valid_so_far, input end_of_string, output ready);
endinterface
`default_nettype wire

// ----- src/puv_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// puv_step: per-byte decode step
// Next validator state and running verdict for one byte, purely combinational.
// ----------------------------------------------------------------------------
module puv_step
    import puv_pkg::*;
(
    input  puv_state_t        cur,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              last_byte,
    output puv_state_t        nxt,
    output logic              valid_so_far
);

    logic [CODE_W-1:0] shifted_code;
    logic [1:0]        owed_dec;
    puv_state_t        upd;

    assign shifted_code = {cur.partial_code[CODE_W-7:0], data_byte[5:0]};
    assign owed_dec     = cur.bytes_owed - 2'd1;

    always_comb
    begin
        upd = cur;
        if (!cur.error_seen)
        begin
            if (cur.bytes_owed == 2'd0)
            begin
                if (data_byte < ASCII_TOP)
                begin
                    if (code_is_bad({{(CODE_W-BYTE_W){1'b0}}, data_byte}, CLS_ONE))
                        upd = STATE_ERROR;
                end
                else if (data_byte >= LEAD2_LO && data_byte <= LEAD2_HI)
                begin
                    upd.partial_code = {{(CODE_W-5){1'b0}}, data_byte[4:0]};
                    upd.bytes_owed   = 2'd1;
                    upd.length_class = CLS_TWO;
                end
                else if (data_byte >= LEAD3_LO && data_byte <= LEAD3_HI)
                begin
                    upd.partial_code = {{(CODE_W-4){1'b0}}, data_byte[3:0]};
                    upd.bytes_owed   = 2'd2;
                    upd.length_class = CLS_THREE;
                end
                else if (data_byte >= LEAD4_LO && data_byte <= LEAD4_HI)
                begin
                    upd.partial_code = {{(CODE_W-3){1'b0}}, data_byte[2:0]};
                    upd.bytes_owed   = 2'd3;
                    upd.length_class = CLS_FOUR;
                end
                else
                begin
                    upd = STATE_ERROR;
                end
            end
            else if ((data_byte & CONT_MASK) != CONT_TAG)
            begin
                upd = STATE_ERROR;
            end
            else
            begin
                upd.partial_code = shifted_code;
                upd.bytes_owed   = owed_dec;
                if (owed_dec == 2'd0)
                begin
                    if (code_is_bad(shifted_code, cur.length_class))
                        upd = STATE_ERROR;
                    else
                    begin
                        upd.partial_code = '0;
                        upd.length_class = CLS_ONE;
                    end
                end
            end
        end
    end

    // A sequence still open on the last byte fails the string.
    always_comb
    begin
        valid_so_far = !upd.error_seen;
        nxt          = upd;
        if (last_byte)
        begin
            if (upd.bytes_owed != 2'd0)
                valid_so_far = 1'b0;
            nxt = STATE_IDLE;
        end
    end

endmodule
`default_nettype wire

// ----- src/printable_utf8_validator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// printable_utf8_validator: streaming printable UTF-8 checker
// Checks a string one byte per item and gives a running verdict per byte.
// ----------------------------------------------------------------------------
//  channel | dir | payload                          | handshake
//  --------+-----+----------------------------------+------------------
//  in_ch   | in  | data_byte[7:0], last_byte        | valid/ready
//  out_ch  | out | valid_so_far, end_of_string      | valid/ready
//
//  One byte per clock sustained while out_ch does not stall. Two register
//  stages: an input register, then the decode step and the result register,
//  which loads a byte's result as the byte leaves the input register.
//  The decode state (owed bytes, partial code, length class, error flag)
//  advances with each byte leaving the input register; it sets the rate.
//  Reset (rst_n low, asynchronous) empties both stages and clears the state.
//  A stall on out_ch holds the result and the input register; in_ch.ready
//  falls only once both stages hold an item.
// ----------------------------------------------------------------------------
module printable_utf8_validator
    import puv_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    puv_in_if.sink     in_ch,
    puv_out_if.source  out_ch
);

    // Input stage
    logic              in_v_reg;
    logic              in_v_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    // Result stage
    logic              out_v_reg;
    logic              out_v_next;
    logic              out_vsf_reg;
    logic              out_eos_reg;

    // Decode state
    puv_state_t        state_reg;
    puv_state_t        state_next;
    puv_state_t        step_state;
    logic              step_valid;

    logic              advance;   // result register free to load
    logic              fire;      // input register moves to result stage
    logic              take_in;   // byte accepted on in_ch

    assign advance = !out_v_reg || out_ch.ready;
    assign fire    = in_v_reg && advance;
    assign take_in = in_ch.valid && in_ch.ready;

    assign in_ch.ready = !in_v_reg || advance;

    puv_step u_step (
        .cur          (state_reg),
        .data_byte    (in_byte_reg),
        .last_byte    (in_last_reg),
        .nxt          (step_state),
        .valid_so_far (step_valid)
    );

    always_comb
    begin
        in_v_next  = take_in || (in_v_reg && !fire);
        out_v_next = fire || (out_v_reg && !out_ch.ready);
        state_next = fire ? step_state : state_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
            state_reg <= STATE_IDLE;
        end
        else
        begin
            in_v_reg  <= in_v_next;
            out_v_reg <= out_v_next;
            state_reg <= state_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_byte_reg <= in_ch.data_byte;
            in_last_reg <= in_ch.last_byte;
        end
        if (fire)
        begin
            out_vsf_reg <= step_valid;
            out_eos_reg <= in_last_reg;
        end
    end

    assign out_ch.valid         = out_v_reg;
    assign out_ch.valid_so_far  = out_vsf_reg;
    assign out_ch.end_of_string = out_eos_reg;

endmodule
`default_nettype wire

// ----- src/puv_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// puv_checker: port-level checks of the validator
// Occupancy and stall behaviour seen on the two channels.
// ----------------------------------------------------------------------------
module puv_checker
    import puv_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic out_valid_so_far,
    input wire logic out_end_of_string
);

    logic       in_take;
    logic       out_take;
    logic [1:0] inflight_reg;
    logic [1:0] inflight_next;

    assign in_take  = in_valid && in_ready;
    assign out_take = out_valid && out_ready;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_take && !out_take)
            inflight_next = inflight_reg + 2'd1;
        else if (!in_take && out_take)
            inflight_next = inflight_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= 2'd0;
        else
            inflight_reg <= inflight_next;
    end

    // No result while reset holds.
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result shown during reset");

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_valid_so_far)
            && $stable(out_end_of_string))
        else $error("stalled result changed");

    // At most two items held, and a result only for an accepted byte.
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        (inflight_reg != 2'd3) && (!out_valid || inflight_reg != 2'd0))
        else $error("item count out of range");

    // Both stages full under a stall: input must back off.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready && $past(in_valid && in_ready) |-> !in_ready)
        else $error("byte taken with both stages full");

endmodule

bind printable_utf8_validator puv_checker u_puv_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_valid_so_far  (out_ch.valid_so_far),
    .out_end_of_string (out_ch.end_of_string)
);
`default_nettype wire
